// File: rtl/core/isometric_point_zbuffer_plotter_core_defines.svh
// Assertion macros for the isometric point plotter core.
`ifndef ISOMETRIC_POINT_ZBUFFER_PLOTTER_CORE_DEFINES_SVH
`define ISOMETRIC_POINT_ZBUFFER_PLOTTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ISOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ISOP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/isop_pkg.sv
// Constants, sine table and helpers shared by the plotter core files.
package isop_pkg;

  localparam int MAX_COLUMNS    = 256;
  localparam int MAX_ROWS       = 128;
  localparam int ROLLBACK_DEPTH = 100;
  localparam int SINE_ENTRIES   = 256;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(SINE_ENTRIES) + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [23:0] DEPTH_LOW  = 24'sh800000;
  localparam logic signed [23:0] DEPTH_HIGH = 24'sh7FFFFF;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  localparam logic OP_POINT = 1'b1;

  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_ZOOM       = 3'd2;
  localparam logic [2:0] REG_ANGLE_STEP = 3'd3;
  localparam logic [2:0] REG_SCREEN_W   = 3'd4;
  localparam logic [2:0] REG_SCREEN_H   = 3'd5;

  // Taylor divisors (2k)(2k+1) for k = 1..7
  localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

  typedef logic [16:0] sine_tab_t [0:SINE_ENTRIES];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      t    = (HALF_PI_Q30 * 64'(i)) / SINE_ENTRIES;
      t2   = (t * t) >> 30;
      term = t;
      sum  = '0;
      for (int k = 1; k <= 7; k++) begin
        if (k[0]) begin
          sum = sum + $signed(term);
        end else begin
          sum = sum - $signed(term);
        end
        term = ((term * t2) >> 30) / TAYLOR_DIV[k];
      end
      if (sum < 0) sum = '0;
      sum = (sum + 64'sd8192) >>> 14;
      if (sum > 64'sd65536) sum = 64'sd65536;
      tab[i] = 17'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Quarter-wave lookup, mirrored and negated by quadrant, no interpolation.
  function automatic logic signed [17:0] sine_of(input logic [15:0] ang);
    logic [31:0] scaled;
    logic [IDX_W-1:0] idx;
    logic [16:0] mag;
    scaled = 32'(ang[13:0]) * 32'(SINE_ENTRIES);
    idx    = IDX_W'(scaled >> 14);
    mag    = ang[14] ? SINE_TAB[IDX_W'(SINE_ENTRIES) - idx] : SINE_TAB[idx];
    return ang[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// File: rtl/core/isop_if.sv
// Request and response stream interfaces of the plotter core.
interface isop_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [23:0] common_z;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic               is_head;
  logic               rollback;
  logic [7:0]         body_id;

  modport source (output valid, opcode, common_z, point_x, point_y, point_z, is_head,
                  rollback, body_id, input ready);
  modport sink (input valid, opcode, common_z, point_x, point_y, point_z, is_head,
                rollback, body_id, output ready);
endinterface

interface isop_rsp_if;
  logic               valid;
  logic               ready;
  logic               pixel_write;
  logic [7:0]         pixel_x;
  logic [6:0]         pixel_y;
  logic               show_head;
  logic [7:0]         body_tag;
  logic signed [16:0] adjusted_z;

  modport source (output valid, pixel_write, pixel_x, pixel_y, show_head, body_tag,
                  adjusted_z, input ready);
  modport sink (input valid, pixel_write, pixel_x, pixel_y, show_head, body_tag,
                adjusted_z, output ready);
endinterface

// File: rtl/core/isometric_point_zbuffer_plotter_core.sv
// Point item: steps P0 to P14, then DONE, from accept to result valid; one item in flight at a time, so the next
// request is taken only once the last result has been raised; one shared 27x18 multiplier issues eight products.
// Frame-start item: offset math in F0 to F2, then a depth clear of all 32768 cells, then the result.
// Reset (rst_ni low, asynchronous): registers to defaults, then a pass over all 32768 cells fills the
// depth memory with the lowest depth; no request is taken until it ends (APB writes still are).
// Configuration is accepted at any time through the APB port with no wait states.
`include "isometric_point_zbuffer_plotter_core_defines.svh"

module isometric_point_zbuffer_plotter_core import isop_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  isop_req_if.sink    req_i,
  isop_rsp_if.source  rsp_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CLEAR = 5'd1;
  localparam logic [4:0] ST_F0    = 5'd2;
  localparam logic [4:0] ST_F1    = 5'd3;
  localparam logic [4:0] ST_F2    = 5'd4;
  localparam logic [4:0] ST_DONE  = 5'd5;
  localparam logic [4:0] ST_P0    = 5'd6;
  localparam logic [4:0] ST_P1    = 5'd7;
  localparam logic [4:0] ST_P2    = 5'd8;
  localparam logic [4:0] ST_P3    = 5'd9;
  localparam logic [4:0] ST_P4    = 5'd10;
  localparam logic [4:0] ST_P5    = 5'd11;
  localparam logic [4:0] ST_P6    = 5'd12;
  localparam logic [4:0] ST_P7    = 5'd13;
  localparam logic [4:0] ST_P8    = 5'd14;
  localparam logic [4:0] ST_P9    = 5'd15;
  localparam logic [4:0] ST_P10   = 5'd16;
  localparam logic [4:0] ST_P11   = 5'd17;
  localparam logic [4:0] ST_P12   = 5'd18;
  localparam logic [4:0] ST_P13   = 5'd19;
  localparam logic [4:0] ST_P14   = 5'd20;

  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

  // control and architectural state
  logic [4:0]         state_q;
  logic [CELL_W-1:0]  clr_addr_q;
  logic               clr_frame_q;
  logic               out_valid_q;
  logic signed [23:0] cx_q, cy_q;
  logic [15:0]        zoom_q, step_q;
  logic [8:0]         sw_q;
  logic [7:0]         sh_q;
  logic [15:0]        angle_q;
  logic signed [31:0] offx_q, offy_q;
  logic signed [23:0] fcz_q;

  // request latch
  logic               op_q;
  logic signed [23:0] cz_in_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic               head_q, rb_q;
  logic [7:0]         body_q;

  // datapath
  logic signed [16:0] zadj_q;
  logic signed [24:0] lx_q;
  logic signed [25:0] lz_q;
  logic signed [17:0] s_q, c_q;
  logic signed [44:0] prod_q;
  logic signed [43:0] rx_q, rz_q;
  logic signed [45:0] a_q, b_q;
  logic signed [23:0] depth_q;
  logic signed [63:0] vx_q, vy_q;
  logic signed [31:0] col_q;
  logic signed [30:0] row_q;
  logic               onscr_q;
  logic               win_q;

  // result register
  logic               res_write_q;
  logic [7:0]         res_x_q;
  logic [6:0]         res_y_q;
  logic               res_head_q;
  logic [7:0]         res_body_q;
  logic signed [16:0] res_z_q;

  // depth memory
  logic signed [23:0] dmem [0:CELLS-1];
  logic signed [23:0] rdata_q;
  logic               mem_we;
  logic [CELL_W-1:0]  mem_waddr;
  logic signed [23:0] mem_wdata;
  logic [CELL_W-1:0]  cell_idx;

  logic               req_acc, out_free, is_pt, win;
  logic [8:0]         wu;
  logic [7:0]         hu;
  logic signed [26:0] mul_a;
  logic signed [17:0] mul_b, zm;
  logic signed [44:0] mul_p;
  logic signed [16:0] zadj;
  logic signed [43:0] rz_adj, rz_sh;
  logic signed [23:0] depth_sat;
  logic signed [63:0] vxa, vya;
  logic signed [44:0] bxa, bya;
  logic signed [37:0] offx_d, offy_d;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -38'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign is_pt    = (op_q == OP_POINT);
  assign wu = (sw_q > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : sw_q;
  assign hu = (sh_q > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : sh_q;
  assign zm = $signed({2'b00, zoom_q});

  assign zadj = 17'(z_q) - ((rb_q && !head_q) ? 17'(ROLLBACK_DEPTH) : 17'sd0);

  // depth is rz in Q8, truncated toward zero and saturated
  assign rz_adj = rz_q + (rz_q[43] ? 44'sh000_0000_FFFF : 44'sd0);
  assign rz_sh  = rz_adj >>> 16;
  always_comb begin
    if (rz_sh > 44'(DEPTH_HIGH)) begin
      depth_sat = DEPTH_HIGH;
    end else if (rz_sh < 44'(DEPTH_LOW)) begin
      depth_sat = DEPTH_LOW;
    end else begin
      depth_sat = 24'(rz_sh);
    end
  end

  assign vxa = vx_q + (vx_q[63] ? 64'sh0000_0000_FFFF_FFFF : 64'sd0);
  assign vya = vy_q + (vy_q[63] ? 64'sh0000_0001_FFFF_FFFF : 64'sd0);

  assign bxa = prod_q + (prod_q[44] ? 45'sd255 : 45'sd0);
  assign bya = prod_q + (prod_q[44] ? 45'sd511 : 45'sd0);
  assign offx_d = ($signed({29'b0, wu}) <<< 7) - 38'(bxa >>> 8);
  assign offy_d = ($signed({30'b0, hu}) <<< 7) - 38'(bya >>> 9);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_F0: begin
        mul_a = 27'(cx_q) - 27'(cz_in_q);
        mul_b = zm;
      end
      ST_F1: begin
        mul_a = 27'(cx_q) + 27'(cz_in_q) - (27'(cy_q) <<< 1);
        mul_b = zm;
      end
      ST_P1: begin
        mul_a = 27'(lx_q);
        mul_b = c_q;
      end
      ST_P2: begin
        mul_a = 27'(lz_q);
        mul_b = s_q;
      end
      ST_P3: begin
        mul_a = 27'(lx_q);
        mul_b = s_q;
      end
      ST_P4: begin
        mul_a = 27'(lz_q);
        mul_b = c_q;
      end
      ST_P7: begin
        mul_a = 27'($signed(a_q[45:24]));
        mul_b = zm;
      end
      ST_P8: begin
        mul_a = $signed({3'b000, a_q[23:0]});
        mul_b = zm;
      end
      ST_P9: begin
        mul_a = 27'($signed(b_q[45:24]));
        mul_b = zm;
      end
      ST_P10: begin
        mul_a = $signed({3'b000, b_q[23:0]});
        mul_b = zm;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 45'(mul_a) * 45'(mul_b);

  assign cell_idx = CELL_W'(row_q[ROW_W-1:0]) * CELL_W'(MAX_COLUMNS)
                  + CELL_W'(col_q[COL_W-1:0]);
  assign win  = onscr_q && (depth_q > rdata_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_idx;
    mem_wdata = depth_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = DEPTH_LOW;
      end
      ST_P14: begin
        mem_we = win;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= dmem[cell_idx];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      clr_frame_q <= 1'b0;
      out_valid_q <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      zoom_q      <= 16'd256;
      step_q      <= '0;
      sw_q        <= 9'd256;
      sh_q        <= 8'd128;
      angle_q     <= '0;
      offx_q      <= '0;
      offy_q      <= '0;
      fcz_q       <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_CENTER_X:   cx_q   <= pwdata[23:0];
          REG_CENTER_Y:   cy_q   <= pwdata[23:0];
          REG_ZOOM:       zoom_q <= pwdata[15:0];
          REG_ANGLE_STEP: step_q <= pwdata[15:0];
          REG_SCREEN_W:   sw_q   <= pwdata[8:0];
          REG_SCREEN_H:   sh_q   <= pwdata[7:0];
          default: ;
        endcase
      end
      if (rsp_o.valid && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + CELL_W'(1);
          if (clr_addr_q == LAST_CELL) begin
            state_q <= clr_frame_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_i.valid) begin
            state_q <= (req_i.opcode == OP_POINT) ? ST_P0 : ST_F0;
          end
        end
        ST_F0: begin
          angle_q <= angle_q + step_q;
          fcz_q   <= cz_in_q;
          state_q <= ST_F1;
        end
        ST_F1: begin
          offx_q  <= sat32(offx_d);
          state_q <= ST_F2;
        end
        ST_F2: begin
          offy_q      <= sat32(offy_d);
          clr_addr_q  <= '0;
          clr_frame_q <= 1'b1;
          state_q     <= ST_CLEAR;
        end
        ST_P14: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          // advance through the point steps
          if (state_q inside {[ST_P0:ST_P13]}) begin
            state_q <= state_q + 5'd1;
          end else begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (req_acc) begin
      op_q    <= req_i.opcode;
      cz_in_q <= req_i.common_z;
      x_q     <= req_i.point_x;
      y_q     <= req_i.point_y;
      z_q     <= req_i.point_z;
      head_q  <= req_i.is_head;
      rb_q    <= req_i.rollback;
      body_q  <= req_i.body_id;
    end
    case (state_q)
      ST_P0: begin
        zadj_q <= zadj;
        lx_q   <= (25'(x_q) <<< 8) - 25'(cx_q);
        lz_q   <= (26'(zadj) <<< 8) - 26'(fcz_q);
        s_q    <= sine_of(angle_q);
        c_q    <= sine_of(angle_q + QUARTER_TURN);
      end
      ST_P2: rx_q <= 44'(prod_q) + (44'(cx_q) <<< 16);
      ST_P3: rx_q <= rx_q - 44'(prod_q);
      ST_P4: rz_q <= 44'(prod_q) + (44'(fcz_q) <<< 16);
      ST_P5: rz_q <= rz_q + 44'(prod_q);
      ST_P6: begin
        a_q     <= 46'(rx_q) - 46'(rz_q);
        b_q     <= 46'(rx_q) + 46'(rz_q) - (46'(y_q) <<< 25);
        depth_q <= depth_sat;
      end
      ST_P8:  vx_q <= (64'(prod_q) + 64'(offx_q)) <<< 24;
      ST_P9:  vx_q <= vx_q + 64'(prod_q);
      ST_P10: vy_q <= (64'(prod_q) + (64'(offy_q) <<< 1)) <<< 24;
      ST_P11: vy_q <= vy_q + 64'(prod_q);
      ST_P12: begin
        col_q <= 32'(vxa >>> 32);
        row_q <= 31'(vya >>> 33);
      end
      ST_P13: begin
        onscr_q <= !col_q[31] && (col_q < $signed({23'b0, wu}))
                && !row_q[30] && (row_q < $signed({23'b0, hu}));
      end
      ST_P14: win_q <= win;
      default: ;
    endcase
    if (state_q == ST_DONE && out_free) begin
      res_write_q <= is_pt && win_q;
      res_x_q     <= (is_pt && win_q) ? col_q[7:0] : 8'd0;
      res_y_q     <= (is_pt && win_q) ? row_q[6:0] : 7'd0;
      res_head_q  <= is_pt && head_q;
      res_body_q  <= is_pt ? body_q : 8'd0;
      res_z_q     <= is_pt ? zadj_q : 17'sd0;
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pixel_write = res_write_q;
  assign rsp_o.pixel_x     = res_x_q;
  assign rsp_o.pixel_y     = res_y_q;
  assign rsp_o.show_head   = res_head_q;
  assign rsp_o.body_tag    = res_body_q;
  assign rsp_o.adjusted_z  = res_z_q;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_CENTER_X:   prdata = {8'b0, cx_q};
      REG_CENTER_Y:   prdata = {8'b0, cy_q};
      REG_ZOOM:       prdata = {16'b0, zoom_q};
      REG_ANGLE_STEP: prdata = {16'b0, step_q};
      REG_SCREEN_W:   prdata = {23'b0, sw_q};
      REG_SCREEN_H:   prdata = {24'b0, sh_q};
      default:        prdata = '0;
    endcase
  end

  `ISOP_ASSERT_NXT(a_accept_starts, req_acc, (state_q == ST_F0) || (state_q == ST_P0), "request did not start a sequence")
  `ISOP_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result raised outside done step")
  `ISOP_ASSERT_IMP(a_miss_zero_cell, out_valid_q && !res_write_q, (res_x_q == 8'd0) && (res_y_q == 7'd0), "undrawn result carries a cell")
  `ISOP_ASSERT_NXT(a_clear_holds, (state_q == ST_CLEAR) && (clr_addr_q != LAST_CELL), state_q == ST_CLEAR, "depth clear left early")

endmodule
